// File: src/dlm_pkg.sv
// Shared types and codes for the desk lift memory position controller.
package dlm_pkg;

    typedef logic signed [15:0] pos_t;
    typedef logic [11:0] margin_t;
    typedef logic [2:0] gesture_t;

    typedef enum logic [1:0] {
        CMD_STOP  = 2'd0,
        CMD_UP    = 2'd1,
        CMD_DOWN  = 2'd2,
        CMD_CLICK = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        SLOT_NONE = 2'd0,
        SLOT_LOW  = 2'd1,
        SLOT_HIGH = 2'd2
    } slot_t;

    localparam gesture_t G_IDLE     = 3'd0;
    localparam gesture_t G_UP       = 3'd1;
    localparam gesture_t G_DOWN     = 3'd2;
    localparam gesture_t G_MEM_UP   = 3'd3;
    localparam gesture_t G_MEM_DOWN = 3'd4;
    localparam gesture_t G_SAVE     = 3'd5;

    localparam pos_t LOW_STOP_RESET  = 16'sh0636;
    localparam pos_t HIGH_STOP_RESET = 16'sh1600;
    localparam pos_t POS_MAX         = 16'sh7FFF;

endpackage

// File: src/dlm_if.sv
// Valid/ready channel interfaces for events, results and configuration.
interface dlm_in_if import dlm_pkg::*; ();
    logic     valid;
    logic     ready;
    logic     op;
    gesture_t gesture;
    pos_t     position;

    modport source (output valid, output op, output gesture, output position, input ready);
    modport sink (input valid, input op, input gesture, input position, output ready);
endinterface

interface dlm_out_if import dlm_pkg::*; ();
    logic  valid;
    logic  ready;
    cmd_t  motor_command;
    slot_t save_slot;
    pos_t  save_value;

    modport source (output valid, output motor_command, output save_slot, output save_value,
                    input ready);
    modport sink (input valid, input motor_command, input save_slot, input save_value,
                  output ready);
endinterface

interface dlm_cfg_if import dlm_pkg::*; ();
    logic    valid;
    logic    ready;
    margin_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/desk_lift_memory_position_fsm.sv
// Desk lift controller with manual and memory moves and two saved stops.
//
// Each beat on events is either a button gesture (op 0) or a position report (op 1). The block
// takes one beat per clock cycle: a beat is captured in an input register, evaluated against the
// mode, position and stop registers in a single combinational pass, and any motor command is
// placed in a result register, which drives result. Events that change nothing produce no result
// beat. The state update is the only loop, so the rate is one event per cycle as long as result
// is not stalled. The user must write the deceleration margin through cfg only while the block
// is idle; the block itself does not enforce this.
module desk_lift_memory_position_fsm
    import dlm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    dlm_in_if.sink       events,
    dlm_out_if.source    result,
    dlm_cfg_if.sink      cfg
);

    typedef enum logic [2:0] {
        MODE_STOPPED,
        MODE_UP,
        MODE_DOWN,
        MODE_MEM_UP,
        MODE_MEM_DOWN
    } mode_t;

    logic     s1_valid_reg;
    logic     s1_op_reg;
    gesture_t s1_gesture_reg;
    pos_t     s1_position_reg;

    mode_t    mode_reg, mode_next;
    pos_t     cur_pos_reg, cur_pos_next;
    pos_t     low_stop_reg, low_stop_next;
    pos_t     high_stop_reg, high_stop_next;
    margin_t  margin_reg;

    logic     out_valid_reg;
    cmd_t     out_cmd_reg;
    slot_t    out_slot_reg;
    pos_t     out_value_reg;

    logic     emit;
    cmd_t     cmd;
    slot_t    slot;
    pos_t     value;

    logic               s1_advance;
    logic signed [16:0] delta_low, delta_high;
    logic        [16:0] dist_low, dist_high;
    logic signed [17:0] sum_low;
    logic signed [17:0] sub_high;
    pos_t               new_low, new_high;

    assign s1_advance   = s1_valid_reg && (!out_valid_reg || result.ready);
    assign events.ready = !s1_valid_reg || s1_advance;
    assign cfg.ready    = 1'b1;

    assign result.valid         = out_valid_reg;
    assign result.motor_command = out_cmd_reg;
    assign result.save_slot     = out_slot_reg;
    assign result.save_value    = out_value_reg;

    // Distances are taken at 17 bits so that they never wrap.
    assign delta_low  = 17'(low_stop_reg) - 17'(cur_pos_reg);
    assign delta_high = 17'(high_stop_reg) - 17'(cur_pos_reg);
    assign dist_low   = delta_low[16] ? 17'(-delta_low) : 17'(delta_low);
    assign dist_high  = delta_high[16] ? 17'(-delta_high) : 17'(delta_high);

    // A save only happens at a non-negative position, so only the low stop can overflow.
    assign sum_low  = 18'(cur_pos_reg) + $signed({6'd0, margin_reg});
    assign sub_high = 18'(cur_pos_reg) - $signed({6'd0, margin_reg});
    assign new_low  = (sum_low > 18'(POS_MAX)) ? POS_MAX : sum_low[15:0];
    assign new_high = sub_high[15:0];

    always_comb
    begin
        mode_next      = mode_reg;
        cur_pos_next   = cur_pos_reg;
        low_stop_next  = low_stop_reg;
        high_stop_next = high_stop_reg;
        emit           = 1'b0;
        cmd            = CMD_STOP;
        slot           = SLOT_NONE;
        value          = '0;

        if (s1_op_reg)
        begin
            cur_pos_next = s1_position_reg;
            if (mode_reg == MODE_MEM_UP && s1_position_reg >= high_stop_reg)
            begin
                mode_next = MODE_STOPPED;
                emit      = 1'b1;
            end
            else if (mode_reg == MODE_MEM_DOWN && s1_position_reg <= low_stop_reg)
            begin
                mode_next = MODE_STOPPED;
                emit      = 1'b1;
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_STOPPED:
                begin
                    if (s1_gesture_reg == G_UP)
                    begin
                        mode_next = MODE_UP;
                        emit      = 1'b1;
                        cmd       = CMD_UP;
                    end
                    else if (s1_gesture_reg == G_DOWN)
                    begin
                        mode_next = MODE_DOWN;
                        emit      = 1'b1;
                        cmd       = CMD_DOWN;
                    end
                    else if (s1_gesture_reg == G_MEM_UP && cur_pos_reg < high_stop_reg)
                    begin
                        mode_next = MODE_MEM_UP;
                        emit      = 1'b1;
                        cmd       = CMD_UP;
                    end
                    else if (s1_gesture_reg == G_MEM_DOWN && cur_pos_reg > low_stop_reg)
                    begin
                        mode_next = MODE_MEM_DOWN;
                        emit      = 1'b1;
                        cmd       = CMD_DOWN;
                    end
                    else if (s1_gesture_reg == G_SAVE && !cur_pos_reg[15])
                    begin
                        emit = 1'b1;
                        cmd  = CMD_CLICK;
                        // On a tie the high stop is the one replaced.
                        if (dist_low < dist_high)
                        begin
                            low_stop_next = new_low;
                            slot          = SLOT_LOW;
                            value         = new_low;
                        end
                        else
                        begin
                            high_stop_next = new_high;
                            slot           = SLOT_HIGH;
                            value          = new_high;
                        end
                    end
                end
                MODE_UP:
                begin
                    if (s1_gesture_reg == G_MEM_UP && cur_pos_reg < high_stop_reg)
                    begin
                        mode_next = MODE_MEM_UP;
                    end
                    else if (s1_gesture_reg == G_IDLE)
                    begin
                        mode_next = MODE_STOPPED;
                        emit      = 1'b1;
                    end
                    else if (s1_gesture_reg == G_DOWN)
                    begin
                        mode_next = MODE_DOWN;
                        emit      = 1'b1;
                        cmd       = CMD_DOWN;
                    end
                end
                MODE_DOWN:
                begin
                    if (s1_gesture_reg == G_MEM_DOWN && cur_pos_reg > low_stop_reg)
                    begin
                        mode_next = MODE_MEM_DOWN;
                    end
                    else if (s1_gesture_reg == G_IDLE)
                    begin
                        mode_next = MODE_STOPPED;
                        emit      = 1'b1;
                    end
                    else if (s1_gesture_reg == G_UP)
                    begin
                        mode_next = MODE_UP;
                        emit      = 1'b1;
                        cmd       = CMD_UP;
                    end
                end
                MODE_MEM_UP:
                begin
                    // The motor already runs upward, so the switch to manual is silent.
                    if (s1_gesture_reg == G_UP)
                    begin
                        mode_next = MODE_UP;
                    end
                    else if (s1_gesture_reg == G_DOWN)
                    begin
                        mode_next = MODE_DOWN;
                        emit      = 1'b1;
                        cmd       = CMD_DOWN;
                    end
                end
                MODE_MEM_DOWN:
                begin
                    if (s1_gesture_reg == G_UP)
                    begin
                        mode_next = MODE_UP;
                        emit      = 1'b1;
                        cmd       = CMD_UP;
                    end
                    else if (s1_gesture_reg == G_DOWN)
                    begin
                        mode_next = MODE_DOWN;
                    end
                end
                default:
                begin
                    mode_next = MODE_STOPPED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s1_op_reg       <= 1'b0;
            s1_gesture_reg  <= G_IDLE;
            s1_position_reg <= '0;
            out_valid_reg   <= 1'b0;
            out_cmd_reg     <= CMD_STOP;
            out_slot_reg    <= SLOT_NONE;
            out_value_reg   <= '0;
            mode_reg        <= MODE_STOPPED;
            cur_pos_reg     <= '0;
            low_stop_reg    <= LOW_STOP_RESET;
            high_stop_reg   <= HIGH_STOP_RESET;
            margin_reg      <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                margin_reg <= cfg.data;
            end

            if (events.ready)
            begin
                s1_valid_reg <= events.valid;
                if (events.valid)
                begin
                    s1_op_reg       <= events.op;
                    s1_gesture_reg  <= events.gesture;
                    s1_position_reg <= events.position;
                end
            end

            if (s1_advance)
            begin
                mode_reg      <= mode_next;
                cur_pos_reg   <= cur_pos_next;
                low_stop_reg  <= low_stop_next;
                high_stop_reg <= high_stop_next;
                out_valid_reg <= emit;
                if (emit)
                begin
                    out_cmd_reg   <= cmd;
                    out_slot_reg  <= slot;
                    out_value_reg <= value;
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // A stalled input register must keep its beat until it is evaluated.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_op_reg)
            && $stable(s1_gesture_reg) && $stable(s1_position_reg))
        else $error("input register lost or changed a pending beat");

    // Only a click carries a saved stop.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.save_slot != SLOT_NONE |-> result.motor_command == CMD_CLICK)
        else $error("save slot reported without a click");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.motor_command == CMD_CLICK |-> result.save_slot != SLOT_NONE)
        else $error("click reported without a save slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.save_slot == SLOT_NONE |-> result.save_value == '0)
        else $error("save value nonzero while nothing was saved");

    // A high-stop save reported on the output is the value now held in the high stop.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && emit && slot == SLOT_HIGH |=> high_stop_reg == out_value_reg)
        else $error("saved high stop does not match the reported value");

endmodule

// File: bench/tb_desk_lift_memory_position_fsm.sv
// Testbench for the desk lift controller: directed and random events checked against a model.
`timescale 1ns / 1ps

module tb_desk_lift_memory_position_fsm;
    import dlm_pkg::*;

    localparam logic OP_GESTURE  = 1'b0;
    localparam logic OP_POSITION = 1'b1;
    localparam int   MAX_PRINTS  = 40;
    localparam int   PHASE_ITEMS = 100;

    typedef enum logic [2:0] {
        MODE_STOPPED,
        MODE_UP,
        MODE_DOWN,
        MODE_MEM_UP,
        MODE_MEM_DOWN
    } lift_mode_t;

    typedef struct {
        logic     op;
        gesture_t gesture;
        pos_t     position;
    } lift_event_t;

    typedef struct {
        cmd_t  cmd;
        slot_t slot;
        pos_t  value;
    } motor_beat_t;

    logic clk;
    logic rst_n;

    dlm_in_if  events ();
    dlm_out_if result ();
    dlm_cfg_if cfg ();

    desk_lift_memory_position_fsm dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .events (events),
        .result (result),
        .cfg    (cfg)
    );

    // Model of the controller state, advanced once per accepted event beat.
    lift_mode_t  mode_m   = MODE_STOPPED;
    pos_t        pos_m    = '0;
    pos_t        low_m    = LOW_STOP_RESET;
    pos_t        high_m   = HIGH_STOP_RESET;
    margin_t     margin_m = '0;

    motor_beat_t cmd_due_q[$];
    lift_event_t event_q[$];

    int          errors       = 0;
    int          queued_items = 0;
    int          cfg_writes   = 0;
    bit          event_taken  = 1'b0;
    int          burst_left   = 0;
    int          gap_left     = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    int          ready_phase  = 0;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(string what);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t mismatch: %s", $time, what);
    endtask

    function automatic pos_t sat16(int v);
        if (v > 32767)
            return POS_MAX;
        if (v < -32768)
            return 16'sh8000;
        return pos_t'(v);
    endfunction

    function automatic void due_cmd(cmd_t c, slot_t s, pos_t v);
        motor_beat_t b;
        b.cmd   = c;
        b.slot  = s;
        b.value = v;
        cmd_due_q.push_back(b);
    endfunction

    function automatic void predict_event(lift_event_t e);
        int p;
        int to_low;
        int to_high;
        p = pos_m;
        if (e.op == OP_POSITION)
        begin
            pos_m = e.position;
            if ((mode_m == MODE_MEM_UP && e.position >= high_m) ||
                (mode_m == MODE_MEM_DOWN && e.position <= low_m))
            begin
                mode_m = MODE_STOPPED;
                due_cmd(CMD_STOP, SLOT_NONE, '0);
            end
            return;
        end
        case (mode_m)
            MODE_STOPPED:
            begin
                if (e.gesture == G_UP)
                begin
                    mode_m = MODE_UP;
                    due_cmd(CMD_UP, SLOT_NONE, '0);
                end
                else if (e.gesture == G_DOWN)
                begin
                    mode_m = MODE_DOWN;
                    due_cmd(CMD_DOWN, SLOT_NONE, '0);
                end
                else if (e.gesture == G_MEM_UP && p < high_m)
                begin
                    mode_m = MODE_MEM_UP;
                    due_cmd(CMD_UP, SLOT_NONE, '0);
                end
                else if (e.gesture == G_MEM_DOWN && p > low_m)
                begin
                    mode_m = MODE_MEM_DOWN;
                    due_cmd(CMD_DOWN, SLOT_NONE, '0);
                end
                else if (e.gesture == G_SAVE && p >= 0)
                begin
                    // Distances are taken at full width, so they never wrap.
                    to_low  = low_m - p;
                    to_high = high_m - p;
                    if (to_low < 0)
                        to_low = -to_low;
                    if (to_high < 0)
                        to_high = -to_high;
                    if (to_low < to_high)
                    begin
                        low_m = sat16(p + int'(margin_m));
                        due_cmd(CMD_CLICK, SLOT_LOW, low_m);
                    end
                    else
                    begin
                        high_m = sat16(p - int'(margin_m));
                        due_cmd(CMD_CLICK, SLOT_HIGH, high_m);
                    end
                end
            end
            MODE_UP:
            begin
                if (e.gesture == G_MEM_UP && p < high_m)
                    mode_m = MODE_MEM_UP;
                else if (e.gesture == G_IDLE)
                begin
                    mode_m = MODE_STOPPED;
                    due_cmd(CMD_STOP, SLOT_NONE, '0);
                end
                else if (e.gesture == G_DOWN)
                begin
                    mode_m = MODE_DOWN;
                    due_cmd(CMD_DOWN, SLOT_NONE, '0);
                end
            end
            MODE_DOWN:
            begin
                if (e.gesture == G_MEM_DOWN && p > low_m)
                    mode_m = MODE_MEM_DOWN;
                else if (e.gesture == G_IDLE)
                begin
                    mode_m = MODE_STOPPED;
                    due_cmd(CMD_STOP, SLOT_NONE, '0);
                end
                else if (e.gesture == G_UP)
                begin
                    mode_m = MODE_UP;
                    due_cmd(CMD_UP, SLOT_NONE, '0);
                end
            end
            MODE_MEM_UP:
            begin
                if (e.gesture == G_UP)
                    mode_m = MODE_UP;
                else if (e.gesture == G_DOWN)
                begin
                    mode_m = MODE_DOWN;
                    due_cmd(CMD_DOWN, SLOT_NONE, '0);
                end
            end
            MODE_MEM_DOWN:
            begin
                if (e.gesture == G_UP)
                begin
                    mode_m = MODE_UP;
                    due_cmd(CMD_UP, SLOT_NONE, '0);
                end
                else if (e.gesture == G_DOWN)
                    mode_m = MODE_DOWN;
            end
            default:
                mode_m = MODE_STOPPED;
        endcase
    endfunction

    // The field that the op does not use carries random content.
    function automatic void queue_event(logic op, gesture_t g, pos_t p);
        lift_event_t e;
        e.op       = op;
        e.gesture  = (op == OP_GESTURE) ? g : gesture_t'($urandom);
        e.position = (op == OP_POSITION) ? p : pos_t'($urandom);
        event_q.push_back(e);
        if (op == OP_POSITION || g <= G_SAVE)
            queued_items++;
    endfunction

    task automatic add_random_sequence();
        int kind;
        int steps;
        int start;
        int target;
        int v;
        bit up;
        kind = $urandom_range(0, 9);
        up   = $urandom_range(0, 1);
        if (kind <= 2)
        begin
            // Memory move toward a stop; the last report may fall short or overshoot.
            queue_event(OP_GESTURE, up ? G_MEM_UP : G_MEM_DOWN, '0);
            target = up ? int'(high_m) : int'(low_m);
            start  = pos_m;
            steps  = $urandom_range(1, 5);
            for (int i = 1; i <= steps; i++)
            begin
                v = start + (target - start) * i / steps + int'($urandom_range(0, 64)) - 32;
                queue_event(OP_POSITION, G_IDLE, sat16(v));
                if ($urandom_range(0, 7) == 0)
                    queue_event(OP_GESTURE, gesture_t'($urandom_range(0, 4)), '0);
            end
            queue_event(OP_GESTURE, G_IDLE, '0);
        end
        else if (kind <= 4)
        begin
            queue_event(OP_GESTURE, up ? G_UP : G_DOWN, '0);
            v     = pos_m;
            steps = $urandom_range(1, 6);
            for (int i = 0; i < steps; i++)
            begin
                v = up ? v + int'($urandom_range(0, 600)) : v - int'($urandom_range(0, 600));
                queue_event(OP_POSITION, G_IDLE, sat16(v));
                if ($urandom_range(0, 3) == 0)
                    queue_event(OP_GESTURE, up ? G_MEM_UP : G_MEM_DOWN, '0);
            end
            queue_event(OP_GESTURE, G_IDLE, '0);
        end
        else if (kind <= 6)
        begin
            // Down then idle brings every mode back to stopped before the save.
            queue_event(OP_GESTURE, G_DOWN, '0);
            queue_event(OP_GESTURE, G_IDLE, '0);
            case ($urandom_range(0, 5))
                0: v = -int'($urandom_range(1, 32768));
                1: v = 32767 - int'($urandom_range(0, 5000));
                2: v = (int'(low_m) + int'(high_m)) / 2;
                3: v = int'(low_m) + int'($urandom_range(0, 3000)) - 1500;
                default: v = int'(high_m) + int'($urandom_range(0, 3000)) - 1500;
            endcase
            queue_event(OP_POSITION, G_IDLE, sat16(v));
            queue_event(OP_GESTURE, G_SAVE, '0);
        end
        else
        begin
            steps = $urandom_range(1, 4);
            for (int i = 0; i < steps; i++)
                queue_event(logic'($urandom_range(0, 1)), gesture_t'($urandom_range(0, 7)),
                            pos_t'($urandom));
        end
    endtask

    task automatic settle_idle();
        while (event_q.size() != 0 || events.valid || cmd_due_q.size() != 0)
            @(negedge clk);
        // Events that give no result may still be in the pipeline.
        repeat (4) @(negedge clk);
    endtask

    task automatic write_margin(margin_t m);
        int seen;
        seen = cfg_writes;
        cfg.valid <= 1'b1;
        cfg.data  <= m;
        while (cfg_writes == seen)
            @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Event driver: bursts of beats from the pending queue with random gaps between them.
    always @(negedge clk)
    begin
        if (rst_n && !(events.valid && !event_taken))
        begin
            if (gap_left > 0 || event_q.size() == 0)
            begin
                events.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
            else
            begin
                events.valid    <= 1'b1;
                events.op       <= event_q[0].op;
                events.gesture  <= event_q[0].gesture;
                events.position <= event_q[0].position;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
        end
        event_taken = 1'b0;
    end

    // Result stalls follow a 16-bit ready pattern, repeated and redrawn whenever ready_phase wraps to zero.
    always @(negedge clk)
    begin
        if (ready_phase == 0)
        begin
            case ($urandom_range(0, 3))
                0: ready_pattern = 16'hFFFF;
                1: ready_pattern = 16'($urandom) | 16'h0001;
                2: ready_pattern = 16'($urandom & $urandom) | 16'h0001;
                default: ready_pattern = 16'($urandom | $urandom);
            endcase
        end
        result.ready <= ready_pattern[ready_phase % 16];
        ready_phase = (ready_phase + 1) % 64;
    end

    always @(posedge clk)
    begin : beat_monitor
        motor_beat_t due;
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                if (cmd_due_q.size() == 0)
                    report_mismatch($sformatf("unexpected result beat cmd %0d slot %0d value %0d",
                                              result.motor_command, result.save_slot,
                                              result.save_value));
                else
                begin
                    due = cmd_due_q.pop_front();
                    if (result.motor_command !== due.cmd)
                        report_mismatch($sformatf("motor_command %0d, expected %0d",
                                                  result.motor_command, due.cmd));
                    if (result.save_slot !== due.slot)
                        report_mismatch($sformatf("save_slot %0d, expected %0d",
                                                  result.save_slot, due.slot));
                    if (result.save_value !== due.value)
                        report_mismatch($sformatf("save_value %0d, expected %0d",
                                                  result.save_value, due.value));
                end
            end
            if (events.valid && events.ready)
            begin
                predict_event(event_q.pop_front());
                event_taken = 1'b1;
            end
            if (cfg.valid && cfg.ready)
            begin
                margin_m = cfg.data;
                cfg_writes++;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int      goal;
        margin_t phase_margin[5];
        events.valid    = 1'b0;
        events.op       = OP_GESTURE;
        events.gesture  = G_IDLE;
        events.position = '0;
        result.ready    = 1'b0;
        cfg.valid       = 1'b0;
        cfg.data        = '0;
        rst_n           = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk through every mode, including the silent manual-to-memory switches.
        queue_event(OP_GESTURE, G_UP, '0);
        queue_event(OP_GESTURE, G_SAVE, '0);
        queue_event(OP_GESTURE, G_MEM_UP, '0);
        queue_event(OP_GESTURE, G_DOWN, '0);
        queue_event(OP_POSITION, G_IDLE, 16'sh1000);
        queue_event(OP_GESTURE, G_MEM_DOWN, '0);
        queue_event(OP_GESTURE, G_IDLE, '0);
        queue_event(OP_GESTURE, G_UP, '0);
        queue_event(OP_GESTURE, G_IDLE, '0);
        queue_event(OP_GESTURE, G_MEM_UP, '0);
        queue_event(OP_POSITION, G_IDLE, 16'sh1600);
        queue_event(OP_GESTURE, G_MEM_DOWN, '0);
        queue_event(OP_POSITION, G_IDLE, 16'sh8000);
        queue_event(OP_GESTURE, G_SAVE, '0);
        queue_event(OP_GESTURE, gesture_t'(7), '0);
        queue_event(OP_POSITION, G_IDLE, POS_MAX);
        queue_event(OP_GESTURE, G_SAVE, '0);
        queue_event(OP_POSITION, G_IDLE, '0);
        queue_event(OP_GESTURE, G_SAVE, '0);
        settle_idle();

        // With the widest margin these saves pull the high stop below the low one,
        // saturate the low stop at the top, and end on an equal-distance save.
        write_margin(12'd4095);
        queue_event(OP_POSITION, G_IDLE, 16'sd20000);
        queue_event(OP_GESTURE, G_SAVE, '0);
        queue_event(OP_POSITION, G_IDLE, 16'sd8000);
        queue_event(OP_GESTURE, G_SAVE, '0);
        queue_event(OP_POSITION, G_IDLE, 16'sd2000);
        queue_event(OP_GESTURE, G_SAVE, '0);
        queue_event(OP_POSITION, G_IDLE, 16'sd100);
        queue_event(OP_GESTURE, G_SAVE, '0);
        queue_event(OP_POSITION, G_IDLE, POS_MAX);
        queue_event(OP_GESTURE, G_SAVE, '0);
        queue_event(OP_POSITION, G_IDLE, 16'sd15336);
        queue_event(OP_GESTURE, G_SAVE, '0);
        settle_idle();

        phase_margin = '{12'd1, margin_t'($urandom), 12'd2048, 12'd4095, 12'd0};
        foreach (phase_margin[i])
        begin
            write_margin(phase_margin[i]);
            goal = queued_items + PHASE_ITEMS;
            while (queued_items < goal)
            begin
                while (event_q.size() > 3)
                    @(negedge clk);
                add_random_sequence();
            end
            settle_idle();
        end

        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
